@@ rtl/line_rasterizer_assert.svh @@
// assertion macros for the line rasterizer
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked check, held off while reset is asserted
`define LR_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define LR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LR_ASSERT_CLK(label, prop, msg)
`define LR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/lr_pkg.sv @@
// shared types and constants of the line rasterizer
package lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FW_BITS    = 13;
  localparam int ADDR_BITS  = 24;
  localparam int COLOR_BITS = 24;
  localparam int ERR_BITS   = 14;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET = 13'd640;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  pixel_addr;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } out_item_t;

endpackage

@@ rtl/line_rasterizer.sv @@
// top level of the bresenham line rasterizer
// a step item's pixel goes to the output register, or to the skid stage while the output holds an item not yet taken
// throughput: one item per cycle while in_stall is low; loads and idle steps give no result item
// in_stall rises only when both the output register and the skid stage hold items
// reset: synchronous active low, clears busy and both output slots, width back to 640
// no clearing pass is needed after reset
`include "line_rasterizer_assert.svh"
module line_rasterizer
  import lr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  // frame width register
  input  logic               cfg_wr_en,
  input  logic [FW_BITS-1:0] cfg_wr_data
);

  logic [FW_BITS-1:0] frame_width_r;
  logic               in_accept;
  logic               produce;
  out_item_t          pix;

  // item accepted when offered and not held off
  assign in_accept = in_valid && !in_stall;

  // frame width, used as written (zero gives address equal to column)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FRAME_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      frame_width_r <= cfg_wr_data;
    end
  end

  // line state, error update and address of the current pixel
  lr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .in_item     (in_item),
    .frame_width (frame_width_r),
    .pix         (pix),
    .produce     (produce)
  );

  // result register plus skid so a new item is taken while one waits
  lr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .produce   (produce),
    .pix       (pix),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a result only ever comes from an accepted step item
  `LR_ASSERT_CLK(a_produce_from_step, produce |-> (in_accept && in_item.op == OP_STEP), "result without step item")
  // out_valid is high in the cycle after a result is produced
  `LR_ASSERT_CLK(a_produce_shows, produce |=> out_valid, "produced result not shown")
  // reset leaves the output empty
  `LR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid && !in_stall), "output not empty after reset")

endmodule

@@ rtl/lr_core.sv @@
// bresenham line state, step update and pixel address
module lr_core
  import lr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  in_item_t           in_item,
  input  logic [FW_BITS-1:0] frame_width,
  output out_item_t          pix,
  output logic               produce
);

  logic [COORD_BITS-1:0]      cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]      cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0]      end_x_r, end_y_r;
  logic [COORD_BITS-1:0]      abs_dx_r, abs_dx_nxt;
  logic signed [COORD_BITS:0] neg_abs_dy_r, neg_abs_dy_nxt;
  logic                       dir_x_neg_r, dir_y_neg_r;
  logic signed [ERR_BITS-1:0] err_r, err_nxt;
  logic [COLOR_BITS-1:0]      color_r;
  logic                       busy_r, busy_nxt;

  logic [COORD_BITS-1:0]      abs_dy;
  logic                       x_lt, y_lt;
  logic                       at_end;
  logic signed [ERR_BITS:0]   e2;
  logic                       step_x, step_y;
  logic [COORD_BITS+FW_BITS-1:0] prod;

  assign x_lt = in_item.x_start < in_item.x_end;
  assign y_lt = in_item.y_start < in_item.y_end;

  always_comb begin
    abs_dx_nxt = x_lt ? (in_item.x_end - in_item.x_start) : (in_item.x_start - in_item.x_end);
    abs_dy     = y_lt ? (in_item.y_end - in_item.y_start) : (in_item.y_start - in_item.y_end);
    neg_abs_dy_nxt = -$signed({1'b0, abs_dy});
  end

  assign at_end  = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
  assign produce = accept && (in_item.op == OP_STEP) && busy_r;

  // doubled error against the two deltas decides the axis moves
  assign e2     = {err_r, 1'b0};
  assign step_x = e2 >= ERR_BITS'(neg_abs_dy_r);
  assign step_y = e2 <= $signed({3'b000, abs_dx_r});

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    err_nxt   = err_r;
    busy_nxt  = busy_r;
    if (accept && (in_item.op == OP_LOAD)) begin
      cur_x_nxt = in_item.x_start;
      cur_y_nxt = in_item.y_start;
      err_nxt   = $signed({2'b00, abs_dx_nxt}) + ERR_BITS'(neg_abs_dy_nxt);
      busy_nxt  = 1'b1;
    end else if (produce) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        err_nxt = err_r
                + (step_x ? ERR_BITS'(neg_abs_dy_r) : '0)
                + (step_y ? $signed({2'b00, abs_dx_r}) : '0);
        if (step_x) begin
          cur_x_nxt = dir_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        end
        if (step_y) begin
          cur_y_nxt = dir_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    err_r   <= err_nxt;
    if (accept && (in_item.op == OP_LOAD)) begin
      end_x_r      <= in_item.x_end;
      end_y_r      <= in_item.y_end;
      abs_dx_r     <= abs_dx_nxt;
      neg_abs_dy_r <= neg_abs_dy_nxt;
      dir_x_neg_r  <= !x_lt;
      dir_y_neg_r  <= !y_lt;
      color_r      <= in_item.color;
    end
  end

  // row times width plus column, wrapped to the address width
  assign prod = (COORD_BITS+FW_BITS)'(cur_y_r) * (COORD_BITS+FW_BITS)'(frame_width);

  always_comb begin
    pix.pixel_x     = cur_x_r;
    pix.pixel_y     = cur_y_r;
    pix.pixel_addr  = ADDR_BITS'(prod + (COORD_BITS+FW_BITS)'(cur_x_r));
    pix.pixel_color = color_r;
    pix.last        = at_end;
  end

endmodule

@@ rtl/lr_outbuf.sv @@
// output register with skid stage for result items
`include "line_rasterizer_assert.svh"
module lr_outbuf
  import lr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      produce,
  input  out_item_t pix,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  out_item_t out_r, skid_r;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      take;
  logic      load_out, load_skid, move_skid;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out  = 1'b0;
    load_skid = 1'b0;
    move_skid = 1'b0;
    if (skid_valid_r) begin
      if (take) begin
        move_skid      = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r || take) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_r <= skid_r;
    end else if (load_out) begin
      out_r <= pix;
    end
    if (load_skid) begin
      skid_r <= pix;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `LR_ASSERT_CLK(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid holds item while output empty")
  `LR_ASSERT_CLK(a_no_produce_full, !(produce && skid_valid_r), "result produced while skid full")
  `LR_ASSERT_CLK(a_skid_drains, (skid_valid_r && take) |=> (out_valid_r && !skid_valid_r), "skid not drained into output")
  `LR_ASSERT_CLK(a_blocked_to_skid, (produce && out_valid_r && !take) |=> skid_valid_r, "blocked result lost")

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the bresenham line rasterizer
module tb_top;
  import lr_pkg::*;

  // run limits: cycle budget is many times the slowest legal run
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_BUDGET   = 650;
  localparam int N_WIDTHS      = 6;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // block ports; the inputs are known from time zero
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_item;
  logic               cfg_wr_en = 1'b0;
  logic [FW_BITS-1:0] cfg_wr_data = '0;

  line_rasterizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // pixel predictor state, mirrors the block after reset
  logic [COORD_BITS-1:0]   cur_col    = '0;
  logic [COORD_BITS-1:0]   cur_row    = '0;
  logic [COORD_BITS-1:0]   end_col    = '0;
  logic [COORD_BITS-1:0]   end_row    = '0;
  logic [COORD_BITS-1:0]   span_x     = '0;
  logic signed [COORD_BITS:0] neg_span_y = '0;
  logic signed [ERR_BITS-1:0] err_acc = '0;
  logic                    x_back     = 1'b0;
  logic                    y_back     = 1'b0;
  logic                    drawing    = 1'b0;
  logic [COLOR_BITS-1:0]   line_rgb   = '0;
  logic [FW_BITS-1:0]      frame_w    = FRAME_WIDTH_RESET;

  // pixels still owed by the block, oldest first
  out_item_t pixel_q[$];
  out_item_t want_px;

  // bookkeeping
  int errors      = 0;
  int cycles      = 0;
  int n_items     = 0;
  int n_loads     = 0;
  int n_pixels    = 0;
  int n_line_ends = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  // directed stimulus row: an item plus an optional hand-written pixel
  typedef struct {
    in_item_t  it;
    bit        pinned;
    out_item_t px;
  } dir_row_t;

  // advance the bresenham state by one accepted item, return 1 if a pixel comes out
  function automatic bit rasterize(input in_item_t it, output out_item_t px);
    int ax, ay, e2;
    px = '0;
    if (it.op == OP_LOAD) begin
      x_back   = !(it.x_start < it.x_end);
      y_back   = !(it.y_start < it.y_end);
      ax = x_back ? int'(it.x_start) - int'(it.x_end) : int'(it.x_end) - int'(it.x_start);
      ay = y_back ? int'(it.y_start) - int'(it.y_end) : int'(it.y_end) - int'(it.y_start);
      cur_col    = it.x_start;
      cur_row    = it.y_start;
      end_col    = it.x_end;
      end_row    = it.y_end;
      span_x     = ax[COORD_BITS-1:0];
      neg_span_y = (COORD_BITS+1)'(-ay);
      err_acc    = ERR_BITS'(ax - ay);
      line_rgb   = it.color;
      drawing    = 1'b1;
      return 1'b0;
    end
    // step with no line running is dropped
    if (!drawing) return 1'b0;
    px.pixel_x     = cur_col;
    px.pixel_y     = cur_row;
    px.pixel_addr  = ADDR_BITS'(longint'(cur_row) * longint'(frame_w) + longint'(cur_col));
    px.pixel_color = line_rgb;
    px.last        = (cur_col == end_col) && (cur_row == end_row);
    if (px.last) begin
      drawing = 1'b0;
    end else begin
      e2 = 2 * int'(err_acc);
      if (e2 >= int'(neg_span_y)) begin
        err_acc = ERR_BITS'(int'(err_acc) + int'(neg_span_y));
        cur_col = x_back ? cur_col - 1'b1 : cur_col + 1'b1;
      end
      if (e2 <= int'(span_x)) begin
        err_acc = ERR_BITS'(int'(err_acc) + int'(span_x));
        cur_row = y_back ? cur_row - 1'b1 : cur_row + 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // table row builders
  function automatic dir_row_t st();
    dir_row_t r;
    r.it    = '0;
    r.it.op = OP_STEP;
    r.pinned = 1'b0;
    r.px    = '0;
    return r;
  endfunction

  function automatic dir_row_t ld(int x0, int y0, int x1, int y1, int rgb);
    dir_row_t r;
    r = st();
    r.it.op      = OP_LOAD;
    r.it.x_start = COORD_BITS'(x0);
    r.it.y_start = COORD_BITS'(y0);
    r.it.x_end   = COORD_BITS'(x1);
    r.it.y_end   = COORD_BITS'(y1);
    r.it.color   = COLOR_BITS'(rgb);
    return r;
  endfunction

  function automatic dir_row_t pin(int x, int y, int addr, int rgb, bit tail);
    dir_row_t r;
    r = st();
    r.pinned         = 1'b1;
    r.px.pixel_x     = COORD_BITS'(x);
    r.px.pixel_y     = COORD_BITS'(y);
    r.px.pixel_addr  = ADDR_BITS'(addr);
    r.px.pixel_color = COLOR_BITS'(rgb);
    r.px.last        = tail;
    return r;
  endfunction

  // random coordinate, biased toward the borders of the 12-bit range
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_BITS'($urandom_range(0, 3));
      1:       return COORD_BITS'(4095 - $urandom_range(0, 3));
      default: return COORD_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // offset a coordinate and keep it on the grid
  function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] base, int delta);
    int v;
    v = int'(base) + delta;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return COORD_BITS'(v);
  endfunction

  // item with every field random, op chosen by the caller
  function automatic in_item_t noise_item(logic op);
    in_item_t r;
    r.op      = op;
    r.x_start = COORD_BITS'($urandom);
    r.y_start = COORD_BITS'($urandom);
    r.x_end   = COORD_BITS'($urandom);
    r.y_end   = COORD_BITS'($urandom);
    r.color   = COLOR_BITS'($urandom);
    return r;
  endfunction

  // offer one item in bursts with random gaps, predict once it is taken
  task automatic feed(in_item_t it, bit pinned, out_item_t pinned_px);
    out_item_t px;
    bit        counts;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // about one burst in four follows straight on without a gap
      if ($urandom_range(0, 3) != 0) begin
        if (in_valid) in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // taken at this edge
    counts = (it.op == OP_LOAD) || drawing;
    if (counts) n_items++;
    if (it.op == OP_LOAD) n_loads++;
    if (rasterize(it, px)) pixel_q.push_back(pinned ? pinned_px : px);
  endtask

  // stop sending and wait until the block owes nothing
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_width(int w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= FW_BITS'(w);
    @(posedge clk);
    frame_w = FW_BITS'(w);
    cfg_wr_en <= 1'b0;
  endtask

  // one random line: mostly complete, sometimes cut short or padded with idle steps
  task automatic draw_random_line();
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    int        len, n_px, cut, dx, dy;
    in_item_t  it;
    out_item_t none;
    none = '0;
    len = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
    x0 = pick_coord();
    y0 = pick_coord();
    x1 = nudge(x0, int'($urandom_range(0, 2 * len)) - len);
    y1 = nudge(y0, int'($urandom_range(0, 2 * len)) - len);
    // stray step ahead of the load, lands idle or on the previous cut line
    if ($urandom_range(0, 19) == 0) feed(noise_item(OP_STEP), 1'b0, none);
    it = noise_item(OP_LOAD);
    it.x_start = x0;
    it.y_start = y0;
    it.x_end   = x1;
    it.y_end   = y1;
    feed(it, 1'b0, none);
    dx = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
    dy = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
    n_px = ((dx > dy) ? dx : dy) + 1;
    // broken sequence: next load restarts the line midway
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_px - 1) : n_px;
    for (int k = 0; k < cut; k++) feed(noise_item(OP_STEP), 1'b0, none);
    // extra step after the endpoint, should be ignored
    if ($urandom_range(0, 9) == 0) feed(noise_item(OP_STEP), 1'b0, none);
  endtask

  // receiver backpressure: free, light, heavy or periodic stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[1];
    endcase
  end

  task automatic flag(string what, logic [23:0] want_v, logic [23:0] got_v);
    $display("%0t mismatch %s: expected %0h got %0h", $time, what, want_v, got_v);
    errors++;
  endtask

  // compare every accepted pixel with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t unexpected pixel: expected none got %0h", $time, out_item);
        errors++;
      end else begin
        want_px = pixel_q.pop_front();
        n_pixels++;
        if (out_item.last) n_line_ends++;
        if (out_item.pixel_x !== want_px.pixel_x)
          flag("pixel_x", want_px.pixel_x, out_item.pixel_x);
        if (out_item.pixel_y !== want_px.pixel_y)
          flag("pixel_y", want_px.pixel_y, out_item.pixel_y);
        if (out_item.pixel_addr !== want_px.pixel_addr)
          flag("pixel_addr", want_px.pixel_addr, out_item.pixel_addr);
        if (out_item.pixel_color !== want_px.pixel_color)
          flag("pixel_color", want_px.pixel_color, out_item.pixel_color);
        if (out_item.last !== want_px.last)
          flag("last", want_px.last, out_item.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles, pixel_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t plan[$];
    int       widths[N_WIDTHS];
    int       per_phase;

    // directed rows, frame width still at its reset value of 640
    plan.push_back(st());                                       // step with no line
    plan.push_back(ld(0, 0, 0, 0, 'hffffff));                   // zero-length line
    plan.push_back(pin(0, 0, 0, 'hffffff, 1'b1));
    plan.push_back(st());                                       // step after endpoint
    plan.push_back(ld(4095, 4095, 4095, 4095, 'h000000));       // single pixel at far corner
    plan.push_back(pin(4095, 4095, 2624895, 'h000000, 1'b1));
    plan.push_back(ld(0, 0, 4095, 4095, 'h123456));             // full diagonal, cut short
    plan.push_back(pin(0, 0, 0, 'h123456, 1'b0));
    plan.push_back(st());
    plan.push_back(ld(4095, 0, 0, 4095, 'habcdef));             // load while busy
    plan.push_back(pin(4095, 0, 4095, 'habcdef, 1'b0));
    plan.push_back(st());
    plan.push_back(ld(10, 20, 13, 18, 'h00ff00));               // shallow, y going up
    plan.push_back(st());
    plan.push_back(st());
    plan.push_back(st());
    plan.push_back(st());
    plan.push_back(ld(7, 9, 6, 3, 'h800001));                   // steep, both directions back
    for (int k = 0; k < 7; k++) plan.push_back(st());

    // frame widths per phase: extremes, zero, full 13 bits, a random one, back to reset
    widths[0] = 1;
    widths[1] = 4096;
    widths[2] = 0;
    widths[3] = 8191;
    widths[4] = $urandom_range(2, 4095);
    widths[5] = 640;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) feed(plan[i].it, plan[i].pinned, plan[i].px);

    per_phase = (ITEM_BUDGET - n_items) / N_WIDTHS;
    for (int p = 0; p < N_WIDTHS; p++) begin
      // width only changes with nothing in flight
      settle();
      set_frame_width(widths[p]);
      while (n_items < 25 + per_phase * (p + 1)) begin
        // now and then hold off until every pixel is back
        if ($urandom_range(0, 39) == 0) settle();
        draw_random_line();
      end
    end

    settle();
    $display("%0d items over %0d frame widths: %0d loads, %0d pixels checked, %0d line ends",
             n_items, N_WIDTHS + 1, n_loads, n_pixels, n_line_ends);
    $display("widths included 0, 1, 4096 and 8191; idle steps and restarts mixed in");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
